// ===== design/dns_query_name_encoder_macros.svh =====
// Assertion macros for the DNS query name encoder.
// Included by the top level; relies on no other file.
`ifndef DNS_QUERY_NAME_ENCODER_MACROS_SVH
`define DNS_QUERY_NAME_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DQE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dqe check failed");

// Next-cycle implication, disabled while reset is low.
`define DQE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dqe check failed");

`endif

// ===== design/dqe_pkg.sv =====
// Shared constants, codes and controller/datapath structs of the DNS query name encoder.
// No dependencies.
package dqe_pkg;

    localparam int MAX_LABEL_DEF = 32;
    localparam int MAX_RESULTS   = 64;
    localparam int CNT_W         = 7;
    localparam int LEN_W         = 10;
    localparam logic [LEN_W-1:0] LEN_MAX = 10'd1023;
    localparam int IDX_W         = 4;
    localparam int HDR_BYTES     = 12;
    localparam int TRL_BYTES     = 4;
    localparam int PADDR_W       = 4;

    localparam logic [7:0] CHR_DOT  = 8'h2E;
    localparam logic [7:0] CHR_NL   = 8'h0A;
    localparam logic [7:0] QD_LO    = 8'h01;
    localparam logic [7:0] ZERO_B   = 8'h00;

    // byte positions inside the header and the trailer
    localparam logic [IDX_W-1:0] HDR_TID_HI = 4'd0;
    localparam logic [IDX_W-1:0] HDR_TID_LO = 4'd1;
    localparam logic [IDX_W-1:0] HDR_FLG_HI = 4'd2;
    localparam logic [IDX_W-1:0] HDR_FLG_LO = 4'd3;
    localparam logic [IDX_W-1:0] HDR_QD_LO  = 4'd5;
    localparam logic [IDX_W-1:0] TRL_TYP_HI = 4'd0;
    localparam logic [IDX_W-1:0] TRL_TYP_LO = 4'd1;
    localparam logic [IDX_W-1:0] TRL_CLS_HI = 4'd2;

    typedef enum logic [1:0] {
        REG_TID    = 2'd0,
        REG_FLAGS  = 2'd1,
        REG_QTYPE  = 2'd2,
        REG_QCLASS = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        SRC_ZERO = 3'd0,
        SRC_HDR  = 3'd1,
        SRC_LEN  = 3'd2,
        SRC_LAB  = 3'd3,
        SRC_TRL  = 3'd4
    } t_src;

    typedef struct packed {
        logic        take;
        logic        idx_clr;
        logic        idx_inc;
        logic        k_inc;
        logic        rd_en;
        logic        load;
        t_src        src;
        logic        last;
        logic        finish;
    } t_ctl;

    typedef struct packed {
        logic in_dot;
        logic in_nl;
        logic dot;
        logic nl;
        logic hdr_sent;
        logic hdr_last;
        logic trl_last;
        logic fill_zero;
        logic k_last;
        logic cap;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [15:0] tid;
        logic [15:0] flags;
        logic [15:0] qtype;
        logic [15:0] qclass;
    } t_cfg;

endpackage

// ===== design/dqe_if.sv =====
// Request channels of the DNS query name encoder: host name characters in, message bytes out.
// Depends on dqe_pkg for the length width.
interface dqe_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

interface dqe_msg_if;
    logic                      valid;
    logic                      ready;
    logic [7:0]                out_byte;
    logic                      run_last;
    logic                      end_of_packet;
    logic                      label_overflow;
    logic [dqe_pkg::LEN_W-1:0] packet_length;

    modport source (output valid, output out_byte, output run_last, output end_of_packet,
                    output label_overflow, output packet_length, input ready);
    modport sink   (input valid, input out_byte, input run_last, input end_of_packet,
                    input label_overflow, input packet_length, output ready);
endinterface

// ===== design/dqe_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module dqe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/dqe_ctrl.sv =====
// Sequencing state machine: walks header, label length, label bytes, terminator and trailer.
// Depends on dqe_pkg for the command and status structs.
module dqe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dqe_pkg::t_sts i_sts,
    output dqe_pkg::t_ctl o_ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_LEN,
        S_LRD,
        S_LOUT,
        S_TERM,
        S_TRL
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        logic seq_last;
        seq_last   = 1'b0;
        n_state    = r_state;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.take    = 1'b1;
                    o_ctl.idx_clr = 1'b1;
                    if (!i_sts.hdr_sent) begin
                        n_state = S_HDR;
                    end else if (i_sts.in_dot || i_sts.in_nl) begin
                        n_state = S_LEN;
                    end
                end
            end
            S_HDR: begin
                if (i_sts.out_free) begin
                    o_ctl.load    = 1'b1;
                    o_ctl.src     = dqe_pkg::SRC_HDR;
                    o_ctl.idx_inc = 1'b1;
                    seq_last = i_sts.hdr_last && !(i_sts.dot || i_sts.nl);
                    if (i_sts.hdr_last) begin
                        n_state = S_LEN;
                    end
                end
            end
            S_LEN: begin
                if (i_sts.out_free) begin
                    o_ctl.load = 1'b1;
                    o_ctl.src  = dqe_pkg::SRC_LEN;
                    seq_last = i_sts.fill_zero && i_sts.dot;
                    n_state  = i_sts.fill_zero ? S_TERM : S_LRD;
                end
            end
            S_LRD: begin
                o_ctl.rd_en = 1'b1;
                n_state     = S_LOUT;
            end
            S_LOUT: begin
                if (i_sts.out_free) begin
                    o_ctl.load  = 1'b1;
                    o_ctl.src   = dqe_pkg::SRC_LAB;
                    o_ctl.k_inc = 1'b1;
                    seq_last = i_sts.k_last && i_sts.dot;
                    n_state  = i_sts.k_last ? S_TERM : S_LRD;
                end
            end
            S_TERM: begin
                if (i_sts.out_free) begin
                    o_ctl.load    = 1'b1;
                    o_ctl.src     = dqe_pkg::SRC_ZERO;
                    o_ctl.idx_clr = 1'b1;
                    n_state       = S_TRL;
                end
            end
            S_TRL: begin
                if (i_sts.out_free) begin
                    o_ctl.load    = 1'b1;
                    o_ctl.src     = dqe_pkg::SRC_TRL;
                    o_ctl.idx_inc = 1'b1;
                    seq_last = i_sts.trl_last;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // the result cap ends the request early; state cleanup still happens
        if (o_ctl.load) begin
            o_ctl.last = seq_last || i_sts.cap;
            if (o_ctl.last) begin
                o_ctl.finish = 1'b1;
                n_state      = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/dqe_dpath.sv =====
// Datapath: label store, name state, sequence counters, byte select and output register.
// Depends on dqe_pkg and dqe_ram.
module dqe_dpath #(
    parameter int MAX_LABEL = dqe_pkg::MAX_LABEL_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dqe_pkg::t_ctl             i_ctl,
    input  dqe_pkg::t_cfg             i_cfg,
    input  logic [7:0]                i_char,
    output dqe_pkg::t_sts             o_sts,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [7:0]                o_out_byte,
    output logic                      o_run_last,
    output logic                      o_eop,
    output logic                      o_ovf,
    output logic [dqe_pkg::LEN_W-1:0] o_len
);

    localparam int FILL_W = $clog2(MAX_LABEL + 1);
    localparam int ADDR_W = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
    localparam int CNT_W  = dqe_pkg::CNT_W;
    localparam int IDX_W  = dqe_pkg::IDX_W;
    localparam int LEN_W  = dqe_pkg::LEN_W;

    logic [7:0]        r_chr;
    logic [FILL_W-1:0] r_fill;
    logic              r_hdr_sent;
    logic [LEN_W-1:0]  r_total;
    logic [LEN_W-1:0]  n_total;
    logic              r_ovf_seen;
    logic [IDX_W-1:0]  r_idx;
    logic [ADDR_W-1:0] r_k;
    logic [CNT_W-1:0]  r_cnt;

    logic              r_valid;
    logic [7:0]        r_byte;
    logic              r_last;
    logic              r_eop;
    logic              r_ovf;
    logic [LEN_W-1:0]  r_len;

    logic              w_in_dot;
    logic              w_in_nl;
    logic              w_dot;
    logic              w_nl;
    logic              w_eop;
    logic              w_we;
    logic [7:0]        w_rdata;
    logic [7:0]        w_byte;

    assign w_in_dot = (i_char == dqe_pkg::CHR_DOT);
    assign w_in_nl  = (i_char == dqe_pkg::CHR_NL);
    assign w_dot    = (r_chr == dqe_pkg::CHR_DOT);
    assign w_nl     = (r_chr == dqe_pkg::CHR_NL);
    assign w_we     = i_ctl.take && !w_in_dot && !w_in_nl && (r_fill < FILL_W'(MAX_LABEL));
    assign w_eop    = i_ctl.last && w_nl;
    assign n_total  = (r_total == dqe_pkg::LEN_MAX) ? r_total : r_total + LEN_W'(1);

    dqe_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LABEL)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (i_char),
        .i_re    (i_ctl.rd_en),
        .i_raddr (r_k),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_byte = dqe_pkg::ZERO_B;
        case (i_ctl.src)
            dqe_pkg::SRC_HDR: begin
                case (r_idx)
                    dqe_pkg::HDR_TID_HI: w_byte = i_cfg.tid[15:8];
                    dqe_pkg::HDR_TID_LO: w_byte = i_cfg.tid[7:0];
                    dqe_pkg::HDR_FLG_HI: w_byte = i_cfg.flags[15:8];
                    dqe_pkg::HDR_FLG_LO: w_byte = i_cfg.flags[7:0];
                    dqe_pkg::HDR_QD_LO:  w_byte = dqe_pkg::QD_LO;
                    default:             w_byte = dqe_pkg::ZERO_B;
                endcase
            end
            dqe_pkg::SRC_TRL: begin
                case (r_idx)
                    dqe_pkg::TRL_TYP_HI: w_byte = i_cfg.qtype[15:8];
                    dqe_pkg::TRL_TYP_LO: w_byte = i_cfg.qtype[7:0];
                    dqe_pkg::TRL_CLS_HI: w_byte = i_cfg.qclass[15:8];
                    default:             w_byte = i_cfg.qclass[7:0];
                endcase
            end
            dqe_pkg::SRC_LEN: w_byte = 8'(r_fill);
            dqe_pkg::SRC_LAB: w_byte = w_rdata;
            default:          w_byte = dqe_pkg::ZERO_B;
        endcase
    end

    // name state and sequence counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_hdr_sent <= 1'b0;
            r_total    <= '0;
            r_ovf_seen <= 1'b0;
            r_idx      <= '0;
            r_k        <= '0;
            r_cnt      <= '0;
        end else begin
            if (i_ctl.take) begin
                r_chr      <= i_char;
                r_hdr_sent <= 1'b1;
                r_k        <= '0;
                r_cnt      <= '0;
                if (w_we) begin
                    r_fill <= r_fill + FILL_W'(1);
                end else if (!w_in_dot && !w_in_nl) begin
                    r_ovf_seen <= 1'b1;
                end
            end
            if (i_ctl.idx_clr) begin
                r_idx <= '0;
            end else if (i_ctl.idx_inc) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_ctl.k_inc) begin
                r_k <= r_k + ADDR_W'(1);
            end
            if (i_ctl.load) begin
                r_cnt   <= r_cnt + CNT_W'(1);
                r_total <= n_total;
            end
            if (i_ctl.finish) begin
                if (w_dot || w_nl) begin
                    r_fill <= '0;
                end
                if (w_nl) begin
                    r_hdr_sent <= 1'b0;
                    r_total    <= '0;
                    r_ovf_seen <= 1'b0;
                end
            end
        end
    end

    // output register: take a new byte whenever the slot is empty or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_byte <= w_byte;
            r_last <= i_ctl.last;
            r_eop  <= w_eop;
            r_ovf  <= r_ovf_seen;
            r_len  <= w_eop ? n_total : '0;
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.in_dot    = w_in_dot;
        o_sts.in_nl     = w_in_nl;
        o_sts.dot       = w_dot;
        o_sts.nl        = w_nl;
        o_sts.hdr_sent  = r_hdr_sent;
        o_sts.hdr_last  = (r_idx == IDX_W'(dqe_pkg::HDR_BYTES - 1));
        o_sts.trl_last  = (r_idx == IDX_W'(dqe_pkg::TRL_BYTES - 1));
        o_sts.fill_zero = (r_fill == '0);
        o_sts.k_last    = ((FILL_W'(r_k) + FILL_W'(1)) == r_fill);
        o_sts.cap       = (r_cnt == CNT_W'(dqe_pkg::MAX_RESULTS - 1));
        o_sts.out_free  = !r_valid || i_out_ready;
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_run_last  = r_last;
    assign o_eop       = r_eop;
    assign o_ovf       = r_ovf;
    assign o_len       = r_len;

endmodule

// ===== design/dns_query_name_encoder.sv =====
// Top level of the DNS query name encoder: register file, controller and datapath.
// Depends on dqe_pkg, dqe_if, dqe_ctrl, dqe_dpath and the assertion macro header.
//
//   channel   dir  handshake            payload
//   i_char    in   valid/ready          character[7:0]
//   o_msg     out  valid/ready          out_byte, run_last, end_of_packet,
//                                       label_overflow, packet_length[9:0]
//   apb       in   psel/penable/pready  paddr[3:0], pwdata/prdata[31:0]
//
// An ordinary character is taken in idle once the header is out; the first character
// of a name adds 12 header bytes, one per cycle via the output register unless stalled.
// A dot sends its length byte; each label byte needs a store read before it is sent.
// A newline sends the same plus the terminator, type and class bytes.
// Output stalls hold the sequencer; input waits while a request is in flight.
// Reset is synchronous; the label store needs no clearing pass.
`include "dns_query_name_encoder_macros.svh"

module dns_query_name_encoder #(
    parameter int MAX_LABEL = dqe_pkg::MAX_LABEL_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dqe_char_if.sink                    i_char,
    dqe_msg_if.source                   o_msg,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dqe_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    dqe_pkg::t_cfg r_cfg;
    dqe_pkg::t_ctl w_ctl;
    dqe_pkg::t_sts w_sts;
    logic          w_wr;
    logic          w_in_ready;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tid    <= 16'h0001;
            r_cfg.flags  <= 16'h0100;
            r_cfg.qtype  <= 16'h0001;
            r_cfg.qclass <= 16'h0001;
        end else if (w_wr) begin
            unique case (dqe_pkg::t_reg_idx'(paddr[3:2]))
                dqe_pkg::REG_TID:    r_cfg.tid    <= pwdata[15:0];
                dqe_pkg::REG_FLAGS:  r_cfg.flags  <= pwdata[15:0];
                dqe_pkg::REG_QTYPE:  r_cfg.qtype  <= pwdata[15:0];
                dqe_pkg::REG_QCLASS: r_cfg.qclass <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (dqe_pkg::t_reg_idx'(paddr[3:2]))
            dqe_pkg::REG_TID:    prdata = {16'h0000, r_cfg.tid};
            dqe_pkg::REG_FLAGS:  prdata = {16'h0000, r_cfg.flags};
            dqe_pkg::REG_QTYPE:  prdata = {16'h0000, r_cfg.qtype};
            dqe_pkg::REG_QCLASS: prdata = {16'h0000, r_cfg.qclass};
            default:             prdata = '0;
        endcase
    end

    dqe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_char.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    assign i_char.ready = w_in_ready;

    dqe_dpath #(
        .MAX_LABEL (MAX_LABEL)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_cfg       (r_cfg),
        .i_char      (i_char.character),
        .o_sts       (w_sts),
        .i_out_ready (o_msg.ready),
        .o_out_valid (o_msg.valid),
        .o_out_byte  (o_msg.out_byte),
        .o_run_last  (o_msg.run_last),
        .o_eop       (o_msg.end_of_packet),
        .o_ovf       (o_msg.label_overflow),
        .o_len       (o_msg.packet_length)
    );

    `DQE_ASSERT_NOW(a_eop_is_last, i_clk, i_rst_n, o_msg.valid && o_msg.end_of_packet, o_msg.run_last)
    `DQE_ASSERT_NOW(a_len_only_eop, i_clk, i_rst_n, o_msg.valid && !o_msg.end_of_packet, o_msg.packet_length == '0)
    `DQE_ASSERT_NOW(a_eop_name_reset, i_clk, i_rst_n, $rose(o_msg.valid && o_msg.end_of_packet), !w_sts.hdr_sent && w_in_ready)
    `DQE_ASSERT_NEXT(a_finish_idle, i_clk, i_rst_n, w_ctl.finish, w_in_ready)

endmodule
